// ===== hdl/lsra_pkg.sv =====
// Shared types and constants for the linear-scan register allocator core.
// Used by every module in this folder; depends on nothing else.
`default_nettype none

package lsra_pkg;

  localparam int ID_W         = 12;
  localparam int POS_W        = 16;
  localparam int OFF_W        = 16;
  localparam int PREG_W       = 3;
  localparam int NUM_REGS_DEF = 6;
  localparam int MAX_IDS      = 4096;
  localparam int SLOT_BYTES   = 4;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   interval_id;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
  } in_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]          result_id;
    logic [PREG_W-1:0]        phys_reg;
    logic                     spilled;
    logic signed [OFF_W-1:0]  spill_offset;
    logic                     last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_CLEAR,
    ACT_SHIFT,
    ACT_DROP,
    ACT_INSERT
  } act_cmd_t;

  typedef struct packed {
    act_cmd_t          cmd;
    logic [POS_W-1:0]  key_end;
    logic [POS_W-1:0]  tail_end;
  } act_ctl_t;

  typedef enum logic [1:0] {
    FREE_HOLD,
    FREE_LOAD,
    FREE_PUSH,
    FREE_POP
  } free_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lsra_act_cell.sv =====
// One cell of the active list, kept sorted by ascending end position.
// Depends on lsra_pkg for the control struct and command codes.
`default_nettype none

module lsra_act_cell
  import lsra_pkg::*;
#(
  parameter int RegW = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire act_ctl_t         ctl,
  input  wire logic             left_valid,
  input  wire logic [POS_W-1:0] left_end,
  input  wire logic [RegW-1:0]  left_reg,
  input  wire logic [ID_W-1:0]  left_id,
  input  wire logic             left_gt,
  input  wire logic             right_valid,
  input  wire logic [POS_W-1:0] right_end,
  input  wire logic [RegW-1:0]  right_reg,
  input  wire logic [ID_W-1:0]  right_id,
  input  wire logic [RegW-1:0]  new_reg,
  input  wire logic [ID_W-1:0]  new_id,
  output logic                  valid_o,
  output logic [POS_W-1:0]      end_o,
  output logic [RegW-1:0]       reg_o,
  output logic [ID_W-1:0]       id_o,
  output logic                  gt_o,
  output logic                  match_o
);

  logic             valid_r, valid_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [RegW-1:0]  reg_r, reg_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;

  assign gt_o    = !valid_r || (end_r > ctl.key_end);
  assign match_o = valid_r && (end_r == ctl.tail_end);

  always_comb begin
    valid_nxt = valid_r;
    end_nxt   = end_r;
    reg_nxt   = reg_r;
    id_nxt    = id_r;
    case (ctl.cmd)
      ACT_CLEAR: begin
        valid_nxt = 1'b0;
      end
      ACT_SHIFT, ACT_DROP: begin
        if (ctl.cmd == ACT_SHIFT || match_o) begin
          valid_nxt = right_valid;
          end_nxt   = right_end;
          reg_nxt   = right_reg;
          id_nxt    = right_id;
        end
      end
      ACT_INSERT: begin
        if (gt_o) begin
          if (left_gt) begin
            valid_nxt = left_valid;
            end_nxt   = left_end;
            reg_nxt   = left_reg;
            id_nxt    = left_id;
          end else begin
            valid_nxt = 1'b1;
            end_nxt   = ctl.key_end;
            reg_nxt   = new_reg;
            id_nxt    = new_id;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    reg_r <= reg_nxt;
    id_r  <= id_nxt;
  end

  assign valid_o = valid_r;
  assign end_o   = end_r;
  assign reg_o   = reg_r;
  assign id_o    = id_r;

endmodule

`default_nettype wire

// ===== hdl/lsra_free_cell.sv =====
// One cell of the free-register stack; cell zero is the top of the stack.
// Depends on lsra_pkg for the stack command codes.
`default_nettype none

module lsra_free_cell
  import lsra_pkg::*;
#(
  parameter int RegW = 3,
  parameter int Slot = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire free_cmd_t       cmd,
  input  wire logic [RegW-1:0] left_reg,
  input  wire logic [RegW-1:0] right_reg,
  output logic [RegW-1:0]      reg_o
);

  localparam logic [RegW-1:0] InitReg = RegW'(Slot + 1);

  logic [RegW-1:0] reg_r, reg_nxt;

  always_comb begin
    case (cmd)
      FREE_LOAD: reg_nxt = InitReg;
      FREE_PUSH: reg_nxt = left_reg;
      FREE_POP:  reg_nxt = right_reg;
      default:   reg_nxt = reg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r <= InitReg;
    end else begin
      reg_r <= reg_nxt;
    end
  end

  assign reg_o = reg_r;

endmodule

`default_nettype wire

// ===== hdl/linear_scan_register_allocator_core.sv =====
// Top level of the linear-scan register allocator: sequencer, slot counter, output register.
// Depends on lsra_pkg, lsra_act_cell and lsra_free_cell.
//
//   Port group | Direction | Handshake          | Beat
//   in_        | input     | in_valid/in_ready  | in_beat_t, one live interval
//   out_       | output    | out_valid/out_ready| out_beat_t, one allocation result
//   cfg_       | input     | cfg_wr_en only     | frame floor, signed 16 bits
//
// An interval passes from idle through the expiry state to the final send; when an active
// interval is evicted, the victim's spill beat is sent and the insert state runs first.
// Expiry retires one entry of the active-list cell chain per cycle.
// A new beat is taken only once the previous one has left the sequencer; its final
// result may still wait in the output register. Output stalls hold the sequencer.
// Reset is synchronous: the active list empties, the free stack holds r1 on top.
`default_nettype none

module linear_scan_register_allocator_core
  import lsra_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_beat_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_beat_t                    out_data,
  input  wire logic                    cfg_wr_en,
  input  wire logic signed [OFF_W-1:0] cfg_wr_data
);

  localparam int RegW = $clog2(NUM_REGS + 1);
  localparam logic [OFF_W:0] AlignMask = ~((OFF_W + 1)'(SLOT_BYTES - 1));
  localparam logic [OFF_W:0] SlotStep  = (OFF_W + 1)'(SLOT_BYTES);
  localparam logic signed [OFF_W:0]   OffMinWide = {2'b11, {(OFF_W - 1){1'b0}}};
  localparam logic signed [OFF_W-1:0] OffMin     = {1'b1, {(OFF_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_SEND_EVICT,
    ST_INSERT,
    ST_SEND_LAST
  } state_t;

  function automatic logic signed [OFF_W-1:0] sat_align(input logic signed [OFF_W:0] v);
    logic signed [OFF_W:0] a;
    a = v & AlignMask;
    if (a < OffMinWide) begin
      sat_align = OffMin;
    end else begin
      sat_align = a[OFF_W-1:0];
    end
  endfunction

  function automatic logic signed [OFF_W-1:0] first_slot(input logic signed [OFF_W-1:0] ff);
    logic signed [OFF_W:0] w;
    logic signed [OFF_W:0] a;
    w = {ff[OFF_W-1], ff};
    a = w & AlignMask;
    if (a == w) begin
      a = a - SlotStep;
    end
    first_slot = sat_align(a);
  endfunction

  function automatic logic signed [OFF_W-1:0] slot_after(input logic signed [OFF_W-1:0] s);
    slot_after = sat_align({s[OFF_W-1], s} - SlotStep);
  endfunction

  state_t                  state_r;
  in_beat_t                item_r;
  out_beat_t               res_r;
  out_beat_t               out_data_r;
  logic                    out_valid_r;
  logic [RegW-1:0]         ins_reg_r;
  logic [RegW-1:0]         free_cnt_r;
  logic signed [OFF_W-1:0] next_slot_r;
  logic signed [OFF_W-1:0] frame_floor_r;

  act_ctl_t        act_ctl;
  logic [RegW-1:0] act_new_reg;
  free_cmd_t       free_cmd;
  logic [RegW-1:0] free_push;

  logic [NUM_REGS-1:0] c_valid;
  logic [NUM_REGS-1:0] c_gt;
  logic [NUM_REGS-1:0] c_match;
  logic [NUM_REGS-1:0] vic_sel;
  logic [POS_W-1:0]    c_end [NUM_REGS];
  logic [RegW-1:0]     c_reg [NUM_REGS];
  logic [ID_W-1:0]     c_id  [NUM_REGS];
  logic [RegW-1:0]     f_reg [NUM_REGS];

  logic                    in_fire;
  logic                    out_free;
  logic                    out_load;
  logic                    head_exp;
  logic                    can_alloc;
  logic                    do_evict;
  logic [RegW-1:0]         vic_reg;
  logic [ID_W-1:0]         vic_id;
  logic signed [OFF_W-1:0] slot_new;
  logic [ID_W-1:0]         in_id;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r inside {ST_SEND_EVICT, ST_SEND_LAST}) && out_free;
  assign in_id    = ID_W'(32'(in_data.interval_id) % MAX_IDS);
  assign slot_new = slot_after(next_slot_r);

  for (genvar k = 0; k < NUM_REGS; k++) begin : g_act
    logic             l_valid, l_gt, r_valid;
    logic [POS_W-1:0] l_end, r_end;
    logic [RegW-1:0]  l_reg, r_reg;
    logic [ID_W-1:0]  l_id, r_id;

    if (k == 0) begin : g_head
      assign l_valid    = 1'b0;
      assign l_gt       = 1'b0;
      assign l_end      = '0;
      assign l_reg      = '0;
      assign l_id       = '0;
      assign vic_sel[k] = c_match[k];
    end else begin : g_body
      assign l_valid    = c_valid[k-1];
      assign l_gt       = c_gt[k-1];
      assign l_end      = c_end[k-1];
      assign l_reg      = c_reg[k-1];
      assign l_id       = c_id[k-1];
      assign vic_sel[k] = c_match[k] && !c_match[k-1];
    end

    if (k == NUM_REGS - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_end   = '0;
      assign r_reg   = '0;
      assign r_id    = '0;
    end else begin : g_inner
      assign r_valid = c_valid[k+1];
      assign r_end   = c_end[k+1];
      assign r_reg   = c_reg[k+1];
      assign r_id    = c_id[k+1];
    end

    lsra_act_cell #(
      .RegW(RegW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (act_ctl),
      .left_valid (l_valid),
      .left_end   (l_end),
      .left_reg   (l_reg),
      .left_id    (l_id),
      .left_gt    (l_gt),
      .right_valid(r_valid),
      .right_end  (r_end),
      .right_reg  (r_reg),
      .right_id   (r_id),
      .new_reg    (act_new_reg),
      .new_id     (item_r.interval_id),
      .valid_o    (c_valid[k]),
      .end_o      (c_end[k]),
      .reg_o      (c_reg[k]),
      .id_o       (c_id[k]),
      .gt_o       (c_gt[k]),
      .match_o    (c_match[k])
    );
  end

  for (genvar k = 0; k < NUM_REGS; k++) begin : g_free
    logic [RegW-1:0] l_reg, r_reg;

    if (k == 0) begin : g_top
      assign l_reg = free_push;
    end else begin : g_below
      assign l_reg = f_reg[k-1];
    end

    if (k == NUM_REGS - 1) begin : g_bottom
      assign r_reg = '0;
    end else begin : g_above
      assign r_reg = f_reg[k+1];
    end

    lsra_free_cell #(
      .RegW(RegW),
      .Slot(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (free_cmd),
      .left_reg (l_reg),
      .right_reg(r_reg),
      .reg_o    (f_reg[k])
    );
  end

  always_comb begin
    vic_reg = '0;
    vic_id  = '0;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (vic_sel[k]) begin
        vic_reg = vic_reg | c_reg[k];
        vic_id  = vic_id | c_id[k];
      end
    end
  end

  always_comb begin
    head_exp         = c_valid[0] && (c_end[0] < item_r.start_pos);
    can_alloc        = (free_cnt_r != '0);
    do_evict         = c_end[NUM_REGS-1] > item_r.end_pos;
    act_ctl.cmd      = ACT_HOLD;
    act_ctl.key_end  = item_r.end_pos;
    act_ctl.tail_end = c_end[NUM_REGS-1];
    act_new_reg      = f_reg[0];
    free_cmd         = FREE_HOLD;
    free_push        = c_reg[0];
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.op) begin
          act_ctl.cmd = ACT_CLEAR;
          free_cmd    = FREE_LOAD;
        end
      end
      ST_EXPIRE: begin
        if (head_exp) begin
          act_ctl.cmd = ACT_SHIFT;
          free_cmd    = FREE_PUSH;
        end else if (can_alloc) begin
          act_ctl.cmd = ACT_INSERT;
          free_cmd    = FREE_POP;
        end else if (do_evict) begin
          act_ctl.cmd = ACT_DROP;
        end
      end
      ST_INSERT: begin
        act_ctl.cmd = ACT_INSERT;
        act_new_reg = ins_reg_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      free_cnt_r    <= RegW'(NUM_REGS);
      next_slot_r   <= first_slot('0);
      frame_floor_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_floor_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            item_r <= '{op: in_data.op, interval_id: in_id,
                        start_pos: in_data.start_pos, end_pos: in_data.end_pos};
            if (in_data.op) begin
              free_cnt_r  <= RegW'(NUM_REGS);
              next_slot_r <= first_slot(frame_floor_r);
            end
            state_r <= ST_EXPIRE;
          end
        end
        ST_EXPIRE: begin
          if (head_exp) begin
            free_cnt_r <= free_cnt_r + 1'b1;
          end else if (can_alloc) begin
            free_cnt_r         <= free_cnt_r - 1'b1;
            res_r.result_id    <= item_r.interval_id;
            res_r.phys_reg     <= PREG_W'(f_reg[0]);
            res_r.spilled      <= 1'b0;
            res_r.spill_offset <= '0;
            res_r.last         <= 1'b1;
            state_r            <= ST_SEND_LAST;
          end else if (do_evict) begin
            next_slot_r        <= slot_new;
            ins_reg_r          <= vic_reg;
            res_r.result_id    <= vic_id;
            res_r.phys_reg     <= '0;
            res_r.spilled      <= 1'b1;
            res_r.spill_offset <= slot_new;
            res_r.last         <= 1'b0;
            state_r            <= ST_SEND_EVICT;
          end else begin
            next_slot_r        <= slot_new;
            res_r.result_id    <= item_r.interval_id;
            res_r.phys_reg     <= '0;
            res_r.spilled      <= 1'b1;
            res_r.spill_offset <= slot_new;
            res_r.last         <= 1'b1;
            state_r            <= ST_SEND_LAST;
          end
        end
        ST_SEND_EVICT: begin
          if (out_free) begin
            out_data_r <= res_r;
            state_r    <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          res_r.result_id    <= item_r.interval_id;
          res_r.phys_reg     <= PREG_W'(ins_reg_r);
          res_r.spilled      <= 1'b0;
          res_r.spill_offset <= '0;
          res_r.last         <= 1'b1;
          state_r            <= ST_SEND_LAST;
        end
        ST_SEND_LAST: begin
          if (out_free) begin
            out_data_r <= res_r;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== bench/alloc_check_pkg.sv =====
// Scoreboard for the linear-scan register allocator testbench: predicts the result beats of
// each accepted interval and checks the beats that leave the block. Depends on lsra_pkg.
`timescale 1ns / 100ps

package alloc_check_pkg;
  import lsra_pkg::*;

  localparam int NREGS = NUM_REGS_DEF;
  localparam int OFFSET_FLOOR = -32768;

  class alloc_scoreboard;
    int frame_floor;
    int next_slot;
    logic [POS_W-1:0] act_end[NREGS];
    logic [PREG_W-1:0] act_reg[NREGS];
    logic [ID_W-1:0] act_id[NREGS];
    int act_cnt;
    logic [PREG_W-1:0] free_stk[NREGS];
    int free_cnt;
    out_beat_t alloc_q[$];
    int errors;

    function new();
      frame_floor = 0;
      errors = 0;
      for (int i = 0; i < NREGS; i++) begin
        act_end[i] = '0;
        act_reg[i] = '0;
        act_id[i] = '0;
      end
      reload_pool();
    endfunction

    function void set_floor(int v);
      frame_floor = v;
    endfunction

    function int pending();
      return alloc_q.size();
    endfunction

    function int floor4(int v);
      return v & ~32'sd3;
    endfunction

    function int clamp_off(int v);
      return (v < OFFSET_FLOOR) ? OFFSET_FLOOR : v;
    endfunction

    function void reload_pool();
      int a;
      act_cnt = 0;
      for (int i = 0; i < NREGS; i++) free_stk[i] = PREG_W'(NREGS - i);
      free_cnt = NREGS;
      a = floor4(frame_floor);
      if (a >= frame_floor) a -= SLOT_BYTES;
      next_slot = clamp_off(a);
    endfunction

    function int claim_slot();
      next_slot = clamp_off(floor4(next_slot - SLOT_BYTES));
      return next_slot;
    endfunction

    function void remove_entry(int pos);
      for (int i = pos; i + 1 < act_cnt; i++) begin
        act_end[i] = act_end[i + 1];
        act_reg[i] = act_reg[i + 1];
        act_id[i] = act_id[i + 1];
      end
      act_cnt--;
    endfunction

    function void insert_entry(logic [ID_W-1:0] id, logic [POS_W-1:0] e,
                               logic [PREG_W-1:0] r);
      int k;
      if (act_cnt >= NREGS) return;
      k = act_cnt;
      act_cnt++;
      while (k > 0 && act_end[k - 1] > e) begin
        act_end[k] = act_end[k - 1];
        act_reg[k] = act_reg[k - 1];
        act_id[k] = act_id[k - 1];
        k--;
      end
      act_end[k] = e;
      act_reg[k] = r;
      act_id[k] = id;
    endfunction

    function void add_result(logic [ID_W-1:0] id, logic [PREG_W-1:0] r, logic sp,
                             int off, logic lst);
      out_beat_t o;
      o.result_id = id;
      o.phys_reg = r;
      o.spilled = sp;
      o.spill_offset = off[OFF_W-1:0];
      o.last = lst;
      alloc_q.push_back(o);
    endfunction

    function void note_interval(in_beat_t b);
      int j;
      int pos;
      int off;
      logic [POS_W-1:0] best;
      logic [PREG_W-1:0] r;
      logic [ID_W-1:0] victim;
      if (b.op) reload_pool();
      j = 0;
      while (j < act_cnt) begin
        if (act_end[j] < b.start_pos) begin
          if (free_cnt < NREGS) begin
            free_stk[free_cnt] = act_reg[j];
            free_cnt++;
          end
          remove_entry(j);
        end else begin
          j++;
        end
      end
      if (free_cnt > 0) begin
        free_cnt--;
        r = free_stk[free_cnt];
        insert_entry(b.interval_id, b.end_pos, r);
        add_result(b.interval_id, r, 1'b0, 0, 1'b1);
      end else begin
        pos = 0;
        best = act_end[0];
        for (j = 1; j < act_cnt; j++) begin
          if (act_end[j] > best) begin
            best = act_end[j];
            pos = j;
          end
        end
        if (act_cnt > 0 && best > b.end_pos) begin
          victim = act_id[pos];
          r = act_reg[pos];
          off = claim_slot();
          remove_entry(pos);
          add_result(victim, '0, 1'b1, off, 1'b0);
          insert_entry(b.interval_id, b.end_pos, r);
          add_result(b.interval_id, r, 1'b0, 0, 1'b1);
        end else begin
          off = claim_slot();
          add_result(b.interval_id, '0, 1'b1, off, 1'b1);
        end
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (alloc_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, got id=%0d reg=%0d spilled=%0b off=%0d last=%0b",
                 $time, got.result_id, got.phys_reg, got.spilled, got.spill_offset, got.last);
        return;
      end
      want = alloc_q.pop_front();
      if (got.result_id !== want.result_id || got.phys_reg !== want.phys_reg ||
          got.spilled !== want.spilled || got.spill_offset !== want.spill_offset ||
          got.last !== want.last) begin
        errors++;
        $display("%0t: expected id=%0d reg=%0d spilled=%0b off=%0d last=%0b, got id=%0d reg=%0d spilled=%0b off=%0d last=%0b",
                 $time, want.result_id, want.phys_reg, want.spilled, want.spill_offset,
                 want.last, got.result_id, got.phys_reg, got.spilled, got.spill_offset,
                 got.last);
      end
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
// Top-level testbench for linear_scan_register_allocator_core: drives interval beats and the
// frame floor, with random idling on both channels. Depends on lsra_pkg and alloc_check_pkg.
`timescale 1ns / 100ps

module tb;
  import lsra_pkg::*;
  import alloc_check_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 132;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_wr_en = 1'b0;
  logic signed [OFF_W-1:0] cfg_wr_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  alloc_scoreboard sb = new();

  linear_scan_register_allocator_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("linear_scan_register_allocator_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic in_beat_t iv(bit op, int id, int s, int e);
    in_beat_t b;
    b.op = op;
    b.interval_id = id[ID_W-1:0];
    b.start_pos = s[POS_W-1:0];
    b.end_pos = e[POS_W-1:0];
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_interval(b);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_floor(input logic signed [OFF_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_floor(int'(v));
  endtask

  task automatic run_directed();
    send_beat(iv(0, 0, 0, 100));
    send_beat(iv(0, 1, 1, 200));
    send_beat(iv(0, 2, 2, 300));
    send_beat(iv(0, 3, 3, 300));
    send_beat(iv(0, 4, 4, 150));
    send_beat(iv(0, 5, 5, 400));
    send_beat(iv(0, 6, 6, 250));
    send_beat(iv(0, 7, 7, 300));
    send_beat(iv(0, 8, 8, 299));
    send_beat(iv(0, 9, 160, 170));
    send_beat(iv(0, 10, 5, 65535));
    send_beat(iv(0, 4095, 65535, 65535));
    send_beat(iv(0, 11, 65535, 0));
    wait_all_results();
    // The deepest floor: every spill lands on the same saturated slot.
    write_floor(-16'sd32768);
    for (int k = 0; k < 8; k++) send_beat(iv(k == 0, 12 + k, k, 2000 - k));
    wait_all_results();
  endtask

  task automatic run_functions(input int n_items);
    int left_in_func;
    int pos;
    int len;
    int e;
    bit [31:0] r;
    in_beat_t b;
    left_in_func = 0;
    pos = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k > 0 && $urandom_range(99) < 8) begin
        r = $urandom;
        b.op = $urandom_range(1);
        b.interval_id = r[ID_W-1:0];
        b.start_pos = r[POS_W-1:0];
        b.end_pos = r[31:16];
      end else begin
        if (left_in_func == 0) begin
          left_in_func = $urandom_range(4, 40);
          pos = ($urandom_range(9) == 0) ? 65535 - $urandom_range(300) : $urandom_range(60000);
          b.op = 1'b1;
        end else begin
          b.op = 1'b0;
        end
        left_in_func--;
        pos += ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(3);
        if (pos > 65535) pos = 65535;
        case ($urandom_range(19))
          0: len = $urandom_range(65535);
          1, 2, 3, 4, 5: len = $urandom_range(500);
          default: len = $urandom_range(40);
        endcase
        e = pos + len;
        if (e > 65535) e = 65535;
        r = $urandom;
        b.interval_id = r[ID_W-1:0];
        b.start_pos = pos[POS_W-1:0];
        b.end_pos = e[POS_W-1:0];
      end
      send_beat(b);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic signed [OFF_W-1:0] floor_val);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_floor(floor_val);
    run_functions(ITEMS_PER_PHASE);
    wait_all_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_phase(0, 0, 16'sd32767);
    run_phase(76, 0, -16'sd6);
    run_phase(0, 76, 16'($urandom_range(32768) * -1));
    run_phase(28, 28, 16'sd0);
    if (sb.errors == 0) begin
      $display("linear_scan_register_allocator_core verification clean");
    end else begin
      $display("linear_scan_register_allocator_core verification failed");
    end
    $finish;
  end

endmodule
